@@ rtl/core/ciq_pkg.sv @@
// ----------------------------------------------------------------------------
// Coalescing input event queue package
// Shared entry type, flag masks and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ciq_pkg;

  localparam logic [15:0] FLG_WHEEL  = 16'h0200;
  localparam logic [15:0] FLG_HWHEEL = 16'h0400;
  localparam logic [15:0] FLG_MOVE   = 16'h0800;
  localparam logic [15:0] FLG_CLASS  = 16'hF000;
  localparam logic [2:0]  KIND_POINTER = 3'd0;

  localparam logic [2:0] ST_APPENDED  = 3'd0;
  localparam logic [2:0] ST_COALESCED = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_POPPED    = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [7:0]  bits;
    logic [31:0] code;
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] flags;
    logic [2:0]  kind;
  } entry_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic shift_from_right;  // cells at or beyond shift_start take the right neighbour
    logic write_tail;        // the addressed cell loads the new entry
  } cell_ctl_t;

  function automatic logic is_wheel(input entry_t e);
    return (e.kind == KIND_POINTER) && ((e.flags & (FLG_WHEEL | FLG_HWHEEL)) != 16'd0);
  endfunction

  function automatic logic is_motion(input entry_t e);
    return (e.kind == KIND_POINTER) && ((e.flags & FLG_MOVE) != 16'd0) && !is_wheel(e);
  endfunction

  function automatic logic is_droppable(input entry_t e);
    return is_motion(e) || is_wheel(e);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ciq_cell.sv @@
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry; loads the new entry, shifts from its right neighbour or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module ciq_cell (
  input  wire                     clk,
  input  wire ciq_pkg::cell_ctl_t ctl,
  input  wire                     shift_en,
  input  wire                     write_sel,
  input  wire ciq_pkg::entry_t    right_entry,
  input  wire ciq_pkg::entry_t    new_entry,
  output ciq_pkg::entry_t         entry,
  output logic                    droppable
);
  import ciq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.write_tail && write_sel) begin
      entry <= new_entry;
    end else if (ctl.shift_from_right && shift_en) begin
      entry <= right_entry;
    end
  end

  assign droppable = is_droppable(entry);

endmodule

`default_nettype wire

@@ rtl/core/coalescing_input_event_queue.sv @@
// ----------------------------------------------------------------------------
// Coalescing input event queue
// Bounded event queue built as a row of cells with tail coalescing of motion.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_axis   in         request: mode, kind, flags, x, y, code, key bits
//  m_axis   out        status, depth, popped entry, counters
//
// A request is handled in two steps: on acceptance, a priority search over the
// cell flags finds the oldest droppable entry; at commit, the row shifts and is
// written, so a new request is taken only after the last one has committed.
// A pending eviction and a pop both shift the row towards its head.
// The next request is taken while the result waits in the output register;
// its commit is held until that result has been taken.
// Reset clears the fill count and both counters; cell contents are not cleared.
`default_nettype none

module coalescing_input_event_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // mode, event_kind, pointer_flags, pos_x, pos_y, key_code, key_bits (lowest first)
  input  wire  [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // status, depth, out_kind, out_flags, out_x, out_y, out_code, out_key_bits,
  // queued_total, dropped_total (lowest first)
  output logic [183:0] m_axis_tdata
);
  import ciq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t            cells [QUEUE_DEPTH];
  logic              drop_f [QUEUE_DEPTH];
  logic [CW-1:0]     fill_count;
  logic [31:0]       accepted_counter, drop_counter;
  logic              busy;
  logic              commit;
  logic              mode_r;
  entry_t            ev;
  logic [IW-1:0]     evict_idx;
  logic              evict_found;
  logic              out_valid;
  logic [183:0]      out_data;

  logic              found_c;
  logic [IW-1:0]     idx_c;

  always_comb begin
    found_c = 1'b0;
    idx_c = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (drop_f[i] && (i < int'(fill_count))) begin
        found_c = 1'b1;
        idx_c = IW'(i);
      end
    end
  end

  entry_t        tail;
  logic          full;
  logic          coalesce, do_evict, do_append, do_pop;
  logic [CW-1:0] fill_after_evict;
  logic [IW-1:0] shift_start, write_idx;
  cell_ctl_t     ctl;
  logic [2:0]    status;
  entry_t        popped;

  assign commit = busy && (!out_valid || m_axis_tready);

  always_comb begin
    tail = cells[IW'(fill_count - CW'(1))];
    full = (fill_count == CW'(QUEUE_DEPTH));
    coalesce = !mode_r && is_motion(ev) && (fill_count != '0) && is_motion(tail)
               && ((tail.flags & FLG_CLASS) == (ev.flags & FLG_CLASS));
    do_evict = !mode_r && !coalesce && full && !is_droppable(ev) && evict_found;
    fill_after_evict = do_evict ? fill_count - CW'(1) : fill_count;
    do_append = !mode_r && !coalesce && (fill_after_evict != CW'(QUEUE_DEPTH));
    do_pop = mode_r && (fill_count != '0);
    shift_start = do_evict ? evict_idx : '0;
    write_idx = coalesce ? IW'(fill_count - CW'(1)) : IW'(fill_after_evict);
    ctl.shift_from_right = do_evict || do_pop;
    ctl.write_tail = coalesce || do_append;
    popped = do_pop ? cells[0] : '0;
    if (mode_r) status = do_pop ? ST_POPPED : ST_EMPTY;
    else if (coalesce) status = ST_COALESCED;
    else if (do_append) status = do_evict ? ST_EVICTED : ST_APPENDED;
    else status = ST_DROPPED;
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t right;
    if (g == QUEUE_DEPTH - 1) begin : g_end
      assign right = cells[g];
    end else begin : g_mid
      assign right = cells[g+1];
    end
    ciq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .shift_en   (commit && (IW'(g) >= shift_start)),
      .write_sel  (commit && (IW'(g) == write_idx)),
      .right_entry(right),
      .new_entry  (ev),
      .entry      (cells[g]),
      .droppable  (drop_f[g])
    );
  end

  logic [31:0] acc_next, drop_next;
  logic [CW-1:0] fill_next;
  always_comb begin
    acc_next = accepted_counter + ((coalesce || do_append) ? 32'd1 : 32'd0);
    drop_next = drop_counter + (do_evict ? 32'd1 : 32'd0)
                + ((!mode_r && !coalesce && !do_append) ? 32'd1 : 32'd0);
    fill_next = do_pop ? fill_count - CW'(1)
              : (do_append ? fill_after_evict + CW'(1) : fill_after_evict);
  end

  assign s_axis_tready = !busy;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      fill_count <= '0;
      accepted_counter <= '0;
      drop_counter <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        busy <= 1'b1;
        mode_r <= s_axis_tdata[0];
        ev.kind <= s_axis_tdata[3:1];
        ev.flags <= s_axis_tdata[19:4];
        ev.x <= s_axis_tdata[35:20];
        ev.y <= s_axis_tdata[51:36];
        ev.code <= s_axis_tdata[83:52];
        ev.bits <= s_axis_tdata[91:84];
        evict_found <= found_c;
        evict_idx <= idx_c;
      end
      if (commit) begin
        busy <= 1'b0;
        out_valid <= 1'b1;
        fill_count <= fill_next;
        accepted_counter <= acc_next;
        drop_counter <= drop_next;
        out_data <= {19'd0, drop_next, acc_next, popped.bits, popped.code, popped.y,
                     popped.x, popped.flags, popped.kind, 7'(fill_next), status};
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
